### design/fxmd_pkg.sv
// shared types and constants for the fixed point multiply/divide unit
package fxmd_pkg;

   localparam int unsigned WORD_BITS  = 32;
   localparam int unsigned WIDE_BITS  = 64;
   localparam int unsigned DIV_STEPS  = 2;
   localparam int unsigned DIV_STAGES = WIDE_BITS / DIV_STEPS;

   typedef enum logic [1:0] {
      OP_GENERAL = 2'd0,
      OP_FIX_MUL = 2'd1,
      OP_FIX_DIV = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   // control flags that travel with each word down the pipeline
   typedef struct packed {
      logic neg;
      logic dz;
      logic nop;
   } ctl_type;

endpackage

### design/fxmd_front.sv
// front end: operand magnitudes, divisor select, product or scaled numerator
module fxmd_front #(
   parameter int unsigned FRACTION_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   enable,
   input  logic                   valid_in,
   input  logic [1:0]             opcode,
   input  logic signed [31:0]     operand_a,
   input  logic signed [31:0]     operand_b,
   input  logic signed [31:0]     operand_c,
   output logic                   valid_out,
   output logic [63:0]            num_out,
   output logic [31:0]            den_out,
   output fxmd_pkg::ctl_type      ctl_out
);
   import fxmd_pkg::*;

   logic          s1_valid_ff, s1_valid_in;
   logic [31:0]   s1_ma_ff, s1_ma_in;
   logic [31:0]   s1_mb_ff, s1_mb_in;
   logic [31:0]   s1_den_ff, s1_den_in;
   logic          s1_div_ff, s1_div_in;
   ctl_type       s1_ctl_ff, s1_ctl_in;
   logic          s2_valid_ff;
   logic [63:0]   s2_num_ff, s2_num_in;
   logic [31:0]   s2_den_ff;
   ctl_type       s2_ctl_ff;
   logic [31:0]   mc;
   logic          na, nb, nc;

   // magnitudes and signs
   always_comb begin
      na        = operand_a[31];
      nb        = operand_b[31];
      nc        = operand_c[31];
      s1_ma_in  = na ? (~operand_a + 32'd1) : operand_a;
      s1_mb_in  = nb ? (~operand_b + 32'd1) : operand_b;
      mc        = nc ? (~operand_c + 32'd1) : operand_c;
      s1_valid_in = valid_in;
      s1_div_in = 1'b0;
      s1_den_in = 32'd0;
      s1_ctl_in = '{neg: 1'b0, dz: 1'b0, nop: 1'b0};
      unique case (opcode)
         OP_GENERAL: begin
            s1_den_in     = mc;
            s1_ctl_in.neg = na ^ nb ^ nc;
         end
         OP_FIX_MUL: begin
            s1_den_in     = 32'd1 << FRACTION_BITS;
            s1_ctl_in.neg = na ^ nb;
         end
         OP_FIX_DIV: begin
            s1_den_in     = s1_mb_in;
            s1_div_in     = 1'b1;
            s1_ctl_in.neg = na ^ nb;
         end
         default: begin
            s1_ctl_in.nop = 1'b1;
         end
      endcase
      s1_ctl_in.dz = (s1_den_in == 32'd0) && !s1_ctl_in.nop;
   end

   // product or shifted numerator
   always_comb begin
      if (s1_div_ff) begin
         s2_num_in = {32'd0, s1_ma_ff} << FRACTION_BITS;
      end else begin
         s2_num_in = {32'd0, s1_ma_ff} * {32'd0, s1_mb_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (enable) begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         s1_ma_ff  <= s1_ma_in;
         s1_mb_ff  <= s1_mb_in;
         s1_den_ff <= s1_den_in;
         s1_div_ff <= s1_div_in;
         s1_ctl_ff <= s1_ctl_in;
         s2_num_ff <= s2_num_in;
         s2_den_ff <= s1_den_ff;
         s2_ctl_ff <= s1_ctl_ff;
      end
   end

   assign valid_out = s2_valid_ff;
   assign num_out   = s2_num_ff;
   assign den_out   = s2_den_ff;
   assign ctl_out   = s2_ctl_ff;

endmodule

### design/fxmd_div_stage.sv
// one stage of the restoring divider, DIV_STEPS (2) quotient bits per stage
module fxmd_div_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   enable,
   input  logic                   valid_in,
   input  logic [31:0]            rem_in,
   input  logic [63:0]            quo_in,
   input  logic [31:0]            den_in,
   input  fxmd_pkg::ctl_type      ctl_in,
   output logic                   valid_out,
   output logic [31:0]            rem_out,
   output logic [63:0]            quo_out,
   output logic [31:0]            den_out,
   output fxmd_pkg::ctl_type      ctl_out
);
   import fxmd_pkg::*;

   logic          valid_ff;
   logic [31:0]   rem_ff, rem_in_w;
   logic [63:0]   quo_ff, quo_in_w;
   logic [31:0]   den_ff;
   ctl_type       ctl_ff;

   // shift in numerator bits, subtract where the divisor fits
   always_comb begin
      logic [32:0] t;
      logic        ge;
      rem_in_w = rem_in;
      quo_in_w = quo_in;
      for (int i = 0; i < DIV_STEPS; i++) begin
         t  = {rem_in_w, quo_in_w[63]};
         ge = (t >= {1'b0, den_in});
         if (ge) begin
            t = t - {1'b0, den_in};
         end
         rem_in_w = t[31:0];
         quo_in_w = {quo_in_w[62:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff <= rem_in_w;
         quo_ff <= quo_in_w;
         den_ff <= den_in;
         ctl_ff <= ctl_in;
      end
   end

   assign valid_out = valid_ff;
   assign rem_out   = rem_ff;
   assign quo_out   = quo_ff;
   assign den_out   = den_ff;
   assign ctl_out   = ctl_ff;

endmodule

### design/fixed_point_mul_div_unit.sv
// pipeline: 2 front stages (magnitudes, 32x32 multiply or numerator shift), 32 divider
// stages of 2 quotient bits each, 1 sign and overflow output register
// throughput one word per cycle; the whole pipeline holds while a result waits
// synchronous active-high reset clears all valid bits; no other state
// a zero divisor yields result 0 with divide_by_zero set
module fixed_point_mul_div_unit #(
   parameter int unsigned FRACTION_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_opcode,
   input  logic signed [31:0] req_operand_a,
   input  logic signed [31:0] req_operand_b,
   input  logic signed [31:0] req_operand_c,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_result,
   output logic               rsp_overflow,
   output logic               rsp_divide_by_zero
);
   import fxmd_pkg::*;

   logic          enable;
   logic          v  [DIV_STAGES+1];
   logic [31:0]   r  [DIV_STAGES+1];
   logic [63:0]   q  [DIV_STAGES+1];
   logic [31:0]   d  [DIV_STAGES+1];
   ctl_type       c  [DIV_STAGES+1];

   logic          out_valid_ff;
   logic [31:0]   out_result_ff, out_result_in;
   logic          out_ovf_ff, out_ovf_in;
   logic          out_dz_ff, out_dz_in;

   // global advance: hold everything while the output word is not taken
   assign enable    = !out_valid_ff || rsp_ready;
   assign req_ready = enable;

   fxmd_front #(.FRACTION_BITS(FRACTION_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .valid_in  (req_valid),
      .opcode    (req_opcode),
      .operand_a (req_operand_a),
      .operand_b (req_operand_b),
      .operand_c (req_operand_c),
      .valid_out (v[0]),
      .num_out   (q[0]),
      .den_out   (d[0]),
      .ctl_out   (c[0])
   );
   assign r[0] = 32'd0;

   // divider pipeline
   for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
      fxmd_div_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .enable    (enable),
         .valid_in  (v[g]),
         .rem_in    (r[g]),
         .quo_in    (q[g]),
         .den_in    (d[g]),
         .ctl_in    (c[g]),
         .valid_out (v[g+1]),
         .rem_out   (r[g+1]),
         .quo_out   (q[g+1]),
         .den_out   (d[g+1]),
         .ctl_out   (c[g+1])
      );
   end

   // sign, overflow and special cases
   always_comb begin
      logic [63:0] qf;
      logic        neg;
      qf  = q[DIV_STAGES];
      neg = c[DIV_STAGES].neg && (qf != 64'd0);
      if (c[DIV_STAGES].nop || c[DIV_STAGES].dz) begin
         out_result_in = 32'd0;
         out_ovf_in    = 1'b0;
      end else if (neg) begin
         out_result_in = ~qf[31:0] + 32'd1;
         out_ovf_in    = (qf > 64'h0000_0000_8000_0000);
      end else begin
         out_result_in = qf[31:0];
         out_ovf_in    = (qf > 64'h0000_0000_7FFF_FFFF);
      end
      out_dz_in = c[DIV_STAGES].dz;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (enable) begin
         out_valid_ff <= v[DIV_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         out_result_ff <= out_result_in;
         out_ovf_ff    <= out_ovf_in;
         out_dz_ff     <= out_dz_in;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_result         = out_result_ff;
   assign rsp_overflow       = out_ovf_ff;
   assign rsp_divide_by_zero = out_dz_ff;

   // remainder of the last stage is not needed
   logic unused_rem;
   assign unused_rem = ^r[DIV_STAGES] ^ ^d[DIV_STAGES] ^ v[0];

endmodule

### tb/fixed_point_mul_div_unit_check.sv
// checker for the fixed point multiply/divide unit: predicts and compares each result word
module fixed_point_mul_div_unit_check (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [1:0]         req_opcode,
   input  logic signed [31:0] req_operand_a,
   input  logic signed [31:0] req_operand_b,
   input  logic signed [31:0] req_operand_c,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic signed [31:0] rsp_result,
   input  logic               rsp_overflow,
   input  logic               rsp_divide_by_zero,
   output int                 error_count,
   output int                 pending_count
);
   import fxmd_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRACTION_BITS = 16;

   typedef struct packed {
      logic [31:0] result;
      logic        overflow;
      logic        divide_by_zero;
   } answer_type;

   answer_type answer_queue[$];

   function automatic logic [31:0] mag32(logic [31:0] v);
      return v[31] ? (~v + 32'd1) : v;
   endfunction

   // truncating sign-magnitude division with wrap and overflow flag
   function automatic answer_type quotient(logic nn, logic [63:0] nm, logic dn,
                                           logic [63:0] dm);
      answer_type  r;
      logic [63:0] q;
      r = '0;
      if (dm == 64'd0) begin
         r.divide_by_zero = 1'b1;
         return r;
      end
      q = nm / dm;
      if (nn != dn && q != 64'd0) begin
         r.result   = ~q[31:0] + 32'd1;
         r.overflow = q > 64'h8000_0000;
      end else begin
         r.result   = q[31:0];
         r.overflow = q > 64'h7fff_ffff;
      end
      return r;
   endfunction

   function automatic answer_type predict_answer(logic [1:0] op, logic [31:0] a,
                                                 logic [31:0] b, logic [31:0] c);
      logic [63:0] ma, mb;
      answer_type  r;
      ma = {32'd0, mag32(a)};
      mb = {32'd0, mag32(b)};
      r  = '0;
      case (op)
         OP_GENERAL: r = quotient(a[31] ^ b[31], ma * mb, c[31], {32'd0, mag32(c)});
         OP_FIX_MUL: r = quotient(a[31] ^ b[31], ma * mb, 1'b0,
                                  64'd1 << FRACTION_BITS);
         OP_FIX_DIV: r = quotient(a[31], ma << FRACTION_BITS, b[31], mb);
         default:    r = '0;
      endcase
      return r;
   endfunction

   assign pending_count = answer_queue.size();

   // record expectations and compare result words
   always @(posedge clock) begin
      answer_type want;
      if (reset) begin
         error_count <= 0;
      end else begin
         if (req_valid && req_ready)
            answer_queue.push_back(predict_answer(req_opcode, req_operand_a,
                                                  req_operand_b, req_operand_c));
         if (rsp_valid && rsp_ready) begin
            if (answer_queue.size() == 0) begin
               if (error_count < 10)
                  $display("unexpected result word %h", rsp_result);
               error_count <= error_count + 1;
            end else begin
               want = answer_queue.pop_front();
               if (want.result !== rsp_result || want.overflow !== rsp_overflow ||
                   want.divide_by_zero !== rsp_divide_by_zero) begin
                  if (error_count < 10)
                     $display("mismatch: expected %h ov %b dz %b, got %h ov %b dz %b",
                              want.result, want.overflow, want.divide_by_zero,
                              rsp_result, rsp_overflow, rsp_divide_by_zero);
                  error_count <= error_count + 1;
               end
            end
         end
      end
   end
endmodule

### tb/fixed_point_mul_div_unit_test.sv
// testbench top for the fixed point multiply/divide unit: stimulus and verdict
module fixed_point_mul_div_unit_test;
   import fxmd_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_WORDS = 900;
   localparam int WATCHDOG     = 20000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_opcode = '0;
   logic signed [31:0] req_operand_a = '0;
   logic signed [31:0] req_operand_b = '0;
   logic signed [31:0] req_operand_c = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [31:0] rsp_result;
   logic               rsp_overflow;
   logic               rsp_divide_by_zero;
   int                 error_count;
   int                 pending_count;
   int                 idle_cycles = 0;
   bit                 long_hold = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   fixed_point_mul_div_unit dut (.*);
   fixed_point_mul_div_unit_check checker_inst (.*);

   // send one word, after a gap set by the caller; valid stays high into the next word when
   // there is no gap
   task automatic send_word(logic [1:0] op, logic [31:0] a, logic [31:0] b,
                            logic [31:0] c, int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_opcode    <= op;
      req_operand_a <= a;
      req_operand_b <= b;
      req_operand_c <= c;
      do @(posedge clock); while (!req_ready);
   endtask

   // operand with bias toward edge values
   function automatic logic [31:0] pick_operand();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'd0;
         3: return 32'hffff_ffff;
         4: return 32'(signed'($urandom_range(0, 200)) - 100);
         5: return 32'h0001_0000 ^ ($urandom & 32'h0000_ffff);
         6: return $urandom >> $urandom_range(0, 31);
         default: return $urandom;
      endcase
   endfunction

   // receiver stall pattern, with one long hold-off
   initial begin
      int gap;
      @(negedge reset);
      forever begin
         if (long_hold) begin
            rsp_ready <= 1'b0;
            repeat (120) @(posedge clock);
            long_hold = 1'b0;
         end
         gap = $urandom_range(0, 5);
         if ($urandom_range(0, 3) == 0) gap = 0;
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // watchdog on cycles with no handshake
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
         $display("fixed_point_mul_div_unit_test: done, errors");
         $finish;
      end
   end

   initial begin
      logic [31:0] edge_vals[6];
      int g;
      edge_vals = '{32'h8000_0000, 32'h7fff_ffff, 32'd0, 32'hffff_ffff,
                    32'd1, 32'h0001_0000};
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: edges per operation, zero divisors, unused opcode
      foreach (edge_vals[i]) begin
         send_word(OP_GENERAL, edge_vals[i], edge_vals[5 - i], edge_vals[(i + 2) % 6], 0);
         send_word(OP_FIX_MUL, edge_vals[i], edge_vals[(i + 1) % 6], 32'd0, 0);
         send_word(OP_FIX_DIV, edge_vals[i], edge_vals[(i + 3) % 6], 32'd7, 1);
      end
      send_word(OP_GENERAL, 32'h8000_0000, 32'h8000_0000, 32'd0, 0);
      send_word(OP_FIX_DIV, 32'h7fff_ffff, 32'd0, 32'd0, 0);
      send_word(OP_GENERAL, 32'h8000_0000, 32'h8000_0000, 32'hffff_ffff, 0);
      send_word(OP_FIX_DIV, 32'h8000_0000, 32'h0001_0000, 32'd0, 0);
      send_word(OP_NONE, 32'h1234_5678, 32'h9abc_def0, 32'h0fed_cba9, 0);
      send_word(OP_NONE, '1, '1, '1, 0);
      // random words with one long receiver hold-off and one drain pause
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n == 300) long_hold = 1'b1;
         if (n == 600) begin
            req_valid <= 1'b0;
            do @(posedge clock); while (pending_count != 0);
         end
         g = $urandom_range(0, 5);
         if ((n / 50) % 3 == 1) g = 0;
         send_word(($urandom_range(0, 15) == 0) ? OP_NONE : 2'($urandom_range(0, 2)),
                   pick_operand(), pick_operand(), pick_operand(), g);
      end
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (40) @(posedge clock);
      if (error_count == 0)
         $display("fixed_point_mul_div_unit_test: done, clean");
      else
         $display("fixed_point_mul_div_unit_test: done, errors");
      $finish;
   end
endmodule
